// File: rtl/core/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and constants for the steering and speed command framer.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int unsigned AngleW = 12;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned AddrW  = 3;

  // Configuration register indexes
  typedef enum logic [AddrW-1:0] {
    REG_CENTER_ANGLE = 3'd0,
    REG_ANGLE_GAIN   = 3'd1,
    REG_ANGLE_MIN    = 3'd2,
    REG_ANGLE_MAX    = 3'd3,
    REG_SPEED_RATIO  = 3'd4,
    REG_HEADER_BYTE  = 3'd5
  } ssf_reg_e;

  // Byte positions inside one command frame
  typedef enum logic [2:0] {
    BYTE_HEADER   = 3'd0,
    BYTE_ANGLE_HI = 3'd1,
    BYTE_ANGLE_LO = 3'd2,
    BYTE_SPEED_HI = 3'd3,
    BYTE_SPEED_LO = 3'd4,
    BYTE_PAD0     = 3'd5,
    BYTE_PAD1     = 3'd6,
    BYTE_CSUM     = 3'd7
  } ssf_byte_e;

  // One finished frame, ready for serialization
  typedef struct packed {
    logic [ByteW-1:0]  header;
    logic [AngleW-1:0] angle;
    logic [SpeedW-1:0] speed;
    logic [ByteW-1:0]  csum;
  } ssf_frame_t;

endpackage

// File: rtl/core/ssf_frame_tx.sv
// ----------------------------------------------------------------------------
// ssf_frame_tx
// Holds one finished frame and sends it out one byte per transfer.
// ----------------------------------------------------------------------------
module ssf_frame_tx (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  ssf_pkg::ssf_frame_t      frame_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ssf_pkg::ByteW-1:0] frame_byte_o,
  output logic                     last_byte_o
);

  ssf_pkg::ssf_frame_t frame_q;
  logic                valid_q;
  ssf_pkg::ssf_byte_e  pos_q;
  logic                xfer;
  logic                done;

  assign xfer    = valid_q && !out_stall_i;
  assign done    = xfer && (pos_q == ssf_pkg::BYTE_CSUM);
  assign ready_o = !valid_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= ssf_pkg::BYTE_HEADER;
    end else if (load_i && ready_o) begin
      valid_q <= 1'b1;
      pos_q   <= ssf_pkg::BYTE_HEADER;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (xfer) begin
      pos_q <= ssf_pkg::ssf_byte_e'(pos_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      frame_q <= frame_i;
    end
  end

  always_comb begin
    unique case (pos_q)
      ssf_pkg::BYTE_HEADER:   frame_byte_o = frame_q.header;
      ssf_pkg::BYTE_ANGLE_HI: frame_byte_o = {4'd0, frame_q.angle[11:8]};
      ssf_pkg::BYTE_ANGLE_LO: frame_byte_o = frame_q.angle[7:0];
      ssf_pkg::BYTE_SPEED_HI: frame_byte_o = frame_q.speed[15:8];
      ssf_pkg::BYTE_SPEED_LO: frame_byte_o = frame_q.speed[7:0];
      ssf_pkg::BYTE_PAD0:     frame_byte_o = 8'd0;
      ssf_pkg::BYTE_PAD1:     frame_byte_o = 8'd0;
      ssf_pkg::BYTE_CSUM:     frame_byte_o = frame_q.csum;
      default:                frame_byte_o = 8'd0;
    endcase
  end

  assign out_valid_o = valid_q;
  assign last_byte_o = (pos_q == ssf_pkg::BYTE_CSUM);

endmodule

// File: rtl/core/steer_speed_command_framer_core.sv
// Flow: an accepted request passes the input register and the product stage
//   into the frame register, which shows its header byte; bytes follow one per
//   cycle unless out_stall_i holds them, and the input register and product
//   stage refill while a frame drains.
// Reset: config registers return to their defaults and all stages empty.
// ----------------------------------------------------------------------------
// steer_speed_command_framer_core
// Turns (turn rate, linear speed) requests into eight-byte command frames:
// header, steering angle hi/lo, speed hi/lo, two zero bytes, checksum.
// ----------------------------------------------------------------------------
module steer_speed_command_framer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [ssf_pkg::AddrW-1:0] cfg_addr_i,
  input  logic [ssf_pkg::CfgW-1:0]  cfg_wdata_i,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [15:0]        turn_rate_i,
  input  logic signed [15:0]        linear_speed_i,
  // frame byte channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                frame_byte_o,
  output logic                      last_byte_o
);

  localparam logic [11:0] CenterRst = 12'd1391;
  localparam logic [11:0] GainRst   = 12'd652;
  localparam logic [11:0] MinRst    = 12'd800;
  localparam logic [11:0] MaxRst    = 12'd1800;
  localparam logic [7:0]  RatioRst  = 8'd19;
  localparam logic [7:0]  HeaderRst = 8'hAA;

  // --------------------------------------------------------------------------
  // Config registers: the user writes only while the block is idle; unenforced.
  // --------------------------------------------------------------------------
  logic [11:0] center_q, gain_q, min_q, max_q;
  logic [7:0]  ratio_q, header_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CenterRst;
      gain_q   <= GainRst;
      min_q    <= MinRst;
      max_q    <= MaxRst;
      ratio_q  <= RatioRst;
      header_q <= HeaderRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ssf_pkg::REG_CENTER_ANGLE: center_q <= cfg_wdata_i;
        ssf_pkg::REG_ANGLE_GAIN:   gain_q   <= cfg_wdata_i;
        ssf_pkg::REG_ANGLE_MIN:    min_q    <= cfg_wdata_i;
        ssf_pkg::REG_ANGLE_MAX:    max_q    <= cfg_wdata_i;
        ssf_pkg::REG_SPEED_RATIO:  ratio_q  <= cfg_wdata_i[7:0];
        ssf_pkg::REG_HEADER_BYTE:  header_q <= cfg_wdata_i[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshakes: each stage advances when the next one is empty or
  // draining in the same cycle.
  // --------------------------------------------------------------------------
  logic in_valid_q, prod_valid_q;
  logic tx_ready, prod_ready, in_ready;

  assign prod_ready = !prod_valid_q || tx_ready;
  assign in_ready   = !in_valid_q || prod_ready;
  assign in_stall_o = !in_ready;

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic signed [15:0] turn_q, lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      turn_q <= turn_rate_i;
      lin_q  <= linear_speed_i;
    end
  end

  // --------------------------------------------------------------------------
  // Product stage: gain (Q0.12) * turn rate and ratio (Q0.8) * speed.
  // Gain, ratio zero-extend; rate, speed sign-extend to product width; no wrap.
  // --------------------------------------------------------------------------
  logic signed [28:0] gprod_d, gprod_q;
  logic signed [23:0] sprod_d, sprod_q;
  logic               stop_q;

  assign gprod_d = $signed({17'd0, gain_q}) * $signed({{13{turn_q[15]}}, turn_q});
  assign sprod_d = $signed({16'd0, ratio_q}) * $signed({{8{lin_q[15]}}, lin_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (prod_ready) begin
      prod_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ready && in_valid_q) begin
      gprod_q <= gprod_d;
      sprod_q <= sprod_d;
      stop_q  <= (lin_q == 16'sd0);
    end
  end

  // --------------------------------------------------------------------------
  // Frame assembly: floor, clamp, truncate, checksum.
  // --------------------------------------------------------------------------
  logic signed [28:0] steer_num;
  logic signed [16:0] steer_floor, steer_hi, steer_clamp;
  logic signed [24:0] spd_adj;
  logic [11:0]        angle;
  logic [15:0]        speed;
  ssf_pkg::ssf_frame_t frame_d;

  // Steering numerator in Q.12; the arithmetic shift by 12 is a floor.
  assign steer_num   = $signed({5'd0, center_q, 12'd0}) - gprod_q;
  assign steer_floor = steer_num[28:12];

  // Apply the max clamp first, then the min clamp; crossed bounds give min.
  always_comb begin
    steer_hi    = (steer_floor > $signed({5'd0, max_q})) ? $signed({5'd0, max_q})
                                                         : steer_floor;
    steer_clamp = (steer_hi < $signed({5'd0, min_q})) ? $signed({5'd0, min_q})
                                                      : steer_hi;
  end

  // Bias a negative product by 255 so the shift truncates toward zero.
  assign spd_adj = {sprod_q[23], sprod_q} + (sprod_q[23] ? 25'sd255 : 25'sd0);

  // Stop frame: center angle unclamped, zero speed.
  assign angle = stop_q ? center_q : steer_clamp[11:0];
  assign speed = stop_q ? 16'd0 : spd_adj[23:8];

  always_comb begin
    frame_d.header = header_q;
    frame_d.angle  = angle;
    frame_d.speed  = speed;
    frame_d.csum   = header_q + {4'd0, angle[11:8]} + angle[7:0]
                   + speed[15:8] + speed[7:0];
  end

  // --------------------------------------------------------------------------
  // Frame register and byte serializer
  // --------------------------------------------------------------------------
  ssf_frame_tx u_frame_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (prod_valid_q),
    .frame_i      (frame_d),
    .ready_o      (tx_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

// File: rtl/core/ssf_checker.sv
// ----------------------------------------------------------------------------
// ssf_checker
// Port-level checks of frame structure and occupancy for the framer core.
// ----------------------------------------------------------------------------
module ssf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [7:0]                frame_byte_o,
  input logic                      last_byte_o
);

  logic       in_xfer, out_xfer, frame_done;
  logic [2:0] pos_q;
  logic [7:0] sum_q;
  logic [2:0] pending_q;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign frame_done = out_xfer && last_byte_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 3'd0;
      sum_q     <= 8'd0;
      pending_q <= 3'd0;
    end else begin
      if (out_xfer) begin
        pos_q <= pos_q + 3'd1;
        sum_q <= last_byte_o ? 8'd0 : sum_q + frame_byte_o;
      end
      pending_q <= pending_q + {2'd0, in_xfer} - {2'd0, frame_done};
    end
  end

  // A stalled byte holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o)
                                   && $stable(last_byte_o))
    else $error("stalled frame byte changed");

  // The last flag marks exactly every eighth byte.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_byte_o == (pos_q == ssf_pkg::BYTE_CSUM)))
    else $error("last_byte out of frame position");

  // The checksum byte is the low byte of the sum of the seven before it.
  a_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> frame_byte_o == sum_q)
    else $error("frame checksum mismatch");

  // Pad bytes are zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pos_q == ssf_pkg::BYTE_PAD0 || pos_q == ssf_pkg::BYTE_PAD1)
    |-> frame_byte_o == 8'd0)
    else $error("pad byte not zero");

  // No more than three requests in flight, and no frame without a request.
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3 && (!out_valid_o || pending_q != 3'd0))
    else $error("request occupancy out of range");

endmodule

bind steer_speed_command_framer_core ssf_checker u_ssf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);
